// File: sv/dfr_pkg.sv
// Shared types, codes and helpers for the delta frame RLE decoder.
// Used by the parser, the result queue, the output sequencer and the top level.
package dfr_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_GEOM  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes carried by a finish result.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_BAD_SIZE     = 3'd2;
    localparam logic [2:0] ERR_BOUNDS       = 3'd3;
    localparam logic [2:0] ERR_ZERO_RUN     = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd6;

    // Byte positions inside the bounding-box header and a record header.
    localparam logic [2:0] HDR_LEFT_HI   = 3'd1;
    localparam logic [2:0] HDR_TOP_HI    = 3'd3;
    localparam logic [2:0] HDR_RIGHT_HI  = 3'd5;
    localparam logic [2:0] HDR_BOTTOM_HI = 3'd7;
    localparam logic [2:0] REC_CTRL_HI   = 3'd1;
    localparam logic [2:0] REC_X_HI      = 3'd3;
    localparam logic [2:0] REC_Y_LO      = 3'd4;
    localparam logic [2:0] REC_Y_HI      = 3'd5;

    // Queue between the parser and the output sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [13:0]       image_width;
        logic [13:0]       image_height;
        logic [12:0]       pixel_row;
        logic [12:0]       pixel_column;
        logic [6:0]        run_length;
        logic [7:0]        pixel_value;
        logic [2:0]        error_code;
        logic              end_of_run;
    } result_t;

    // One queue entry holds every result caused by one input byte: a main
    // result, optionally followed by a finish result, or a finish result alone.
    typedef struct packed {
        result_t    first;
        logic       has_second;
        logic [2:0] second_code;
    } entry_t;

    function automatic result_t finish_result(input logic [2:0] code, input logic eor);
        result_t r;
        r = '0;
        r.kind = (code == ERR_NONE) ? KIND_DONE : KIND_ERROR;
        r.error_code = code;
        r.end_of_run = eor;
        return r;
    endfunction

endpackage

// File: sv/dfr_in_if.sv
// Input channel of the delta frame RLE decoder: one blob byte per item.
// Stand-alone; no package needed.
interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: sv/dfr_out_if.sv
// Result channel of the delta frame RLE decoder: one result per item.
// Stand-alone; no package needed.
interface dfr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [13:0]        image_width;
    logic [13:0]        image_height;
    logic [12:0]        pixel_row;
    logic [12:0]        pixel_column;
    logic [6:0]         run_length;
    logic [7:0]         pixel_value;
    logic [2:0]         error_code;
    logic               end_of_run;

    modport source (output valid, input ready, output kind, output origin_x,
        output origin_y, output image_width, output image_height, output pixel_row,
        output pixel_column, output run_length, output pixel_value, output error_code,
        output end_of_run);
    modport sink (input valid, output ready, input kind, input origin_x,
        input origin_y, input image_width, input image_height, input pixel_row,
        input pixel_column, input run_length, input pixel_value, input error_code,
        input end_of_run);
endinterface

// File: sv/dfr_front.sv
// Parser of the decoder: accepts blob bytes, tracks header and record state
// and pushes the results of each byte into the queue. Depends on dfr_pkg, dfr_in_if.
module dfr_front #(
    parameter int MAX_DIM = 8192
) (
    input  logic           clk,
    input  logic           rst_n,
    dfr_in_if.sink         blob,
    input  logic           full,
    output logic           push,
    output dfr_pkg::entry_t entry
);
    import dfr_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int POS_W = $clog2(MAX_DIM);

    typedef enum logic [6:0] {
        PH_HDR   = 7'b0000001,
        PH_REC   = 7'b0000010,
        PH_RAW   = 7'b0000100,
        PH_PKT   = 7'b0001000,
        PH_FILL  = 7'b0010000,
        PH_LIT   = 7'b0100000,
        PH_DRAIN = 7'b1000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         idx_reg, idx_next;
    logic [7:0]         hold_reg, hold_next;
    logic [15:0]        left_reg, left_next;
    logic [15:0]        top_reg, top_next;
    logic [15:0]        word_reg, word_next;
    logic [16:0]        col_reg, col_next;
    logic [16:0]        end_reg, end_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   column_reg, column_next;
    logic [14:0]        rem_reg, rem_next;
    logic [6:0]         pkt_reg, pkt_next;

    logic               accept;
    logic               last;
    logic [15:0]        word;
    logic [17:0]        w_calc;
    logic [17:0]        h_calc;
    logic               size_bad;
    logic [16:0]        col_calc;
    logic [16:0]        row_calc;
    logic               bounds_bad;
    logic [6:0]         len;
    logic               have_main;
    result_t            main_res;
    logic               have_fin;
    logic [2:0]         fin_code;
    logic               done;

    assign blob.ready = !full;
    assign accept = blob.valid && blob.ready;
    assign last = blob.last_byte;
    assign word = {blob.data_byte, hold_reg};
    assign len = blob.data_byte[7:1];

    assign w_calc = {{2{word_reg[15]}}, word_reg} - {{2{left_reg[15]}}, left_reg} + 18'd1;
    assign h_calc = {{2{word[15]}}, word} - {{2{top_reg[15]}}, top_reg} + 18'd1;
    assign size_bad = w_calc[17] || (w_calc == '0) || (w_calc > 18'(MAX_DIM))
                   || h_calc[17] || (h_calc == '0) || (h_calc > 18'(MAX_DIM));

    assign col_calc = {word[15], word} - {left_reg[15], left_reg};
    assign row_calc = {word[15], word} - {top_reg[15], top_reg};
    // The record's end column was formed one byte earlier, so only compares remain for it here.
    assign bounds_bad = col_reg[16] || (end_reg > 17'(width_reg))
                     || row_calc[16] || (row_calc[15:0] >= 16'(height_reg));

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        word_next   = word_reg;
        col_next    = col_reg;
        end_next    = end_reg;
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        column_next = column_reg;
        rem_next    = rem_reg;
        pkt_next    = pkt_reg;
        have_main   = 1'b0;
        main_res    = '0;
        have_fin    = 1'b0;
        fin_code    = ERR_NONE;
        done        = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (idx_reg == HDR_BOTTOM_HI)
                    begin
                        if (size_bad)
                        begin
                            have_fin = 1'b1;
                            fin_code = ERR_BAD_SIZE;
                        end
                        else
                        begin
                            width_next = DIM_W'(w_calc);
                            height_next = DIM_W'(h_calc);
                            have_main = 1'b1;
                            main_res.kind = KIND_GEOM;
                            main_res.origin_x = left_reg;
                            main_res.origin_y = top_reg;
                            main_res.image_width = 14'(w_calc);
                            main_res.image_height = 14'(h_calc);
                            phase_next = PH_REC;
                            idx_next = '0;
                            if (last)
                            begin
                                have_fin = 1'b1;
                                fin_code = ERR_NONE;
                            end
                        end
                    end
                    else
                    begin
                        if (idx_reg == HDR_LEFT_HI)
                        begin
                            left_next = word;
                        end
                        if (idx_reg == HDR_TOP_HI)
                        begin
                            top_next = word;
                        end
                        if (idx_reg == HDR_RIGHT_HI)
                        begin
                            word_next = word;
                        end
                        hold_next = blob.data_byte;
                        idx_next = idx_reg + 3'd1;
                        if (last)
                        begin
                            have_fin = 1'b1;
                            fin_code = ERR_SHORT_HEADER;
                        end
                    end
                end

                PH_REC:
                begin
                    if (idx_reg == REC_CTRL_HI && word == '0)
                    begin
                        have_fin = 1'b1;
                        fin_code = ERR_NONE;
                    end
                    else if (idx_reg == REC_Y_HI)
                    begin
                        if (bounds_bad)
                        begin
                            have_fin = 1'b1;
                            fin_code = ERR_BOUNDS;
                        end
                        else
                        begin
                            row_next = POS_W'(row_calc);
                            column_next = POS_W'(col_reg);
                            rem_next = word_reg[15:1];
                            idx_next = '0;
                            if (word_reg[15:1] == '0)
                            begin
                                // An empty record: straight on to the next record header.
                                if (last)
                                begin
                                    have_fin = 1'b1;
                                    fin_code = ERR_NONE;
                                end
                            end
                            else
                            begin
                                phase_next = word_reg[0] ? PH_PKT : PH_RAW;
                                if (last)
                                begin
                                    have_fin = 1'b1;
                                    fin_code = ERR_TRUNCATED;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (idx_reg == REC_CTRL_HI)
                        begin
                            word_next = word;
                        end
                        if (idx_reg == REC_X_HI)
                        begin
                            col_next = col_calc;
                        end
                        if (idx_reg == REC_Y_LO)
                        begin
                            end_next = col_reg + {2'b00, word_reg[15:1]};
                        end
                        hold_next = blob.data_byte;
                        idx_next = idx_reg + 3'd1;
                        if (last)
                        begin
                            have_fin = 1'b1;
                            fin_code = ERR_NONE;
                        end
                    end
                end

                PH_RAW:
                begin
                    have_main = 1'b1;
                    main_res.kind = KIND_WRITE;
                    main_res.pixel_row = 13'(row_reg);
                    main_res.pixel_column = 13'(column_reg);
                    main_res.run_length = 7'd1;
                    main_res.pixel_value = blob.data_byte;
                    column_next = column_reg + POS_W'(1);
                    rem_next = rem_reg - 15'd1;
                    done = (rem_reg == 15'd1);
                    if (done)
                    begin
                        phase_next = PH_REC;
                        idx_next = '0;
                    end
                    if (last)
                    begin
                        have_fin = 1'b1;
                        fin_code = done ? ERR_NONE : ERR_TRUNCATED;
                    end
                end

                PH_PKT:
                begin
                    if (len == '0)
                    begin
                        have_fin = 1'b1;
                        fin_code = ERR_ZERO_RUN;
                    end
                    else if ({8'd0, len} > rem_reg)
                    begin
                        have_fin = 1'b1;
                        fin_code = ERR_OVERFLOW;
                    end
                    else
                    begin
                        pkt_next = len;
                        phase_next = blob.data_byte[0] ? PH_FILL : PH_LIT;
                        if (last)
                        begin
                            have_fin = 1'b1;
                            fin_code = ERR_TRUNCATED;
                        end
                    end
                end

                PH_FILL:
                begin
                    have_main = 1'b1;
                    main_res.kind = KIND_WRITE;
                    main_res.pixel_row = 13'(row_reg);
                    main_res.pixel_column = 13'(column_reg);
                    main_res.run_length = pkt_reg;
                    main_res.pixel_value = blob.data_byte;
                    column_next = column_reg + POS_W'(pkt_reg);
                    rem_next = rem_reg - {8'd0, pkt_reg};
                    pkt_next = '0;
                    phase_next = PH_PKT;
                    // The packet never exceeds what is left, so equality means the record is done.
                    done = (rem_reg == {8'd0, pkt_reg});
                    if (done)
                    begin
                        phase_next = PH_REC;
                        idx_next = '0;
                    end
                    if (last)
                    begin
                        have_fin = 1'b1;
                        fin_code = done ? ERR_NONE : ERR_TRUNCATED;
                    end
                end

                PH_LIT:
                begin
                    have_main = 1'b1;
                    main_res.kind = KIND_WRITE;
                    main_res.pixel_row = 13'(row_reg);
                    main_res.pixel_column = 13'(column_reg);
                    main_res.run_length = 7'd1;
                    main_res.pixel_value = blob.data_byte;
                    column_next = column_reg + POS_W'(1);
                    rem_next = rem_reg - 15'd1;
                    pkt_next = pkt_reg - 7'd1;
                    if (pkt_reg == 7'd1)
                    begin
                        phase_next = PH_PKT;
                    end
                    done = (rem_reg == 15'd1);
                    if (done)
                    begin
                        phase_next = PH_REC;
                        idx_next = '0;
                    end
                    if (last)
                    begin
                        have_fin = 1'b1;
                        fin_code = done ? ERR_NONE : ERR_TRUNCATED;
                    end
                end

                PH_DRAIN:
                begin
                    if (last)
                    begin
                        phase_next = PH_HDR;
                        idx_next = '0;
                    end
                end

                default:
                begin
                    phase_next = PH_HDR;
                    idx_next = '0;
                end
            endcase

            // A finish ends the blob: drain to the last byte, or rearm at once.
            if (have_fin)
            begin
                phase_next = last ? PH_HDR : PH_DRAIN;
                idx_next = '0;
            end
        end
    end

    always_comb
    begin
        entry = '0;
        if (have_main)
        begin
            entry.first = main_res;
            entry.first.end_of_run = !have_fin;
            entry.has_second = have_fin;
            entry.second_code = fin_code;
        end
        else
        begin
            entry.first = finish_result(fin_code, 1'b1);
        end
    end

    assign push = accept && (have_main || have_fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            idx_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        left_reg <= left_next;
        top_reg <= top_next;
        word_reg <= word_next;
        col_reg <= col_next;
        end_reg <= end_next;
        width_reg <= width_next;
        height_reg <= height_next;
        row_reg <= row_next;
        column_reg <= column_next;
        rem_reg <= rem_next;
        pkt_reg <= pkt_next;
    end

endmodule

// File: sv/dfr_queue.sv
// Short queue of per-byte result entries between the parser and the
// output sequencer. Depends on dfr_pkg.
module dfr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dfr_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output dfr_pkg::entry_t pop_entry,
    output logic            not_empty
);
    import dfr_pkg::*;

    entry_t                 slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("queue read while empty");
    a_count_tracks_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH)) |->
        (QUEUE_PTR_W'(count_reg) == QUEUE_PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count disagrees with pointers");
`endif

endmodule

// File: sv/dfr_back.sv
// Output sequencer: turns queue entries into single results on the result channel, one
// per cycle while the sink is ready, behind an output register. Depends on dfr_pkg, dfr_out_if.
module dfr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  dfr_pkg::entry_t entry,
    output logic            pop,
    dfr_out_if.source       result
);
    import dfr_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;
    logic       sec_pend_reg, sec_pend_next;
    logic [2:0] sec_code_reg, sec_code_next;
    logic       fire;

    assign fire = out_valid_reg && result.ready;
    // A new entry loads when the output stage is empty or is being emptied
    // with nothing of the previous entry left to send.
    assign pop = not_empty && (!out_valid_reg || (fire && !sec_pend_reg));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        sec_pend_next = sec_pend_reg;
        sec_code_next = sec_code_reg;
        if (fire && sec_pend_reg)
        begin
            out_next = finish_result(sec_code_reg, 1'b1);
            sec_pend_next = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b1;
            out_next = entry.first;
            sec_pend_next = entry.has_second;
            sec_code_next = entry.second_code;
        end
        else if (fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_pend_reg <= sec_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sec_code_reg <= sec_code_next;
    end

    assign result.valid = out_valid_reg;
    assign result.kind = out_reg.kind;
    assign result.origin_x = out_reg.origin_x;
    assign result.origin_y = out_reg.origin_y;
    assign result.image_width = out_reg.image_width;
    assign result.image_height = out_reg.image_height;
    assign result.pixel_row = out_reg.pixel_row;
    assign result.pixel_column = out_reg.pixel_column;
    assign result.run_length = out_reg.run_length;
    assign result.pixel_value = out_reg.pixel_value;
    assign result.error_code = out_reg.error_code;
    assign result.end_of_run = out_reg.end_of_run;

`ifndef NO_ASSERTIONS
    a_pending_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sec_pend_reg |-> out_valid_reg)
        else $error("second result pending with no result shown");
    a_second_is_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && sec_pend_reg) |=>
        ((out_reg.kind == KIND_DONE || out_reg.kind == KIND_ERROR) && out_reg.end_of_run))
        else $error("second result of a byte is not a closing finish");
    a_write_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_WRITE) |-> (out_reg.run_length != '0))
        else $error("pixel write with zero length");
`endif

endmodule

// File: sv/delta_frame_rle_decoder.sv
// Top level of the delta frame RLE decoder: parser, result queue, output sequencer.
// Depends on dfr_pkg, dfr_in_if, dfr_out_if, dfr_front, dfr_queue, dfr_back.
//
//   Channel  Dir  Item                         Payload
//   blob     in   one byte of the blob         data_byte, last_byte
//   result   out  geometry, write, ok or error kind .. end_of_run
//
// One byte is taken per cycle while the queue is not full. A byte that causes two
// results (geometry or a write followed by a finish) needs the output for both; the four-entry
// queue absorbs this, so the output register sets the sustained rate.
// A result passes through a queue slot and then the output register before it becomes valid.
// Reset is asynchronous and active low; no clearing pass follows it.
// The input stalls only when the queue is full.
module delta_frame_rle_decoder #(
    parameter int MAX_DIM = 8192
) (
    input  logic      clk,
    input  logic      rst_n,
    dfr_in_if.sink    blob,
    dfr_out_if.source result
);
    import dfr_pkg::*;

    logic   push;
    logic   full;
    entry_t push_entry;
    logic   pop;
    logic   not_empty;
    entry_t pop_entry;

    dfr_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .blob  (blob),
        .full  (full),
        .push  (push),
        .entry (push_entry)
    );

    dfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (not_empty)
    );

    dfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .entry     (pop_entry),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: test/delta_frame_rle_decoder_test.sv
// Self-checking testbench for delta_frame_rle_decoder: directed blobs, then random blobs.
// Expected results come from a behavioral decoder kept in this file.
// Depends on dfr_pkg, dfr_in_if, dfr_out_if and the decoder RTL.
`timescale 1ns / 100ps

module delta_frame_rle_decoder_test;
    import dfr_pkg::*;

    typedef enum logic [6:0] {
        ST_HEADER  = 7'b0000001,
        ST_RECORD  = 7'b0000010,
        ST_RAW     = 7'b0000100,
        ST_PACKET  = 7'b0001000,
        ST_FILL    = 7'b0010000,
        ST_LITERAL = 7'b0100000,
        ST_DRAIN   = 7'b1000000
    } parse_state_t;

    // One directed row; a typed row pins the kind and code of its last result.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] code;
    } stim_row_t;

    localparam logic TYPED   = 1'b1;
    localparam logic MODELED = 1'b0;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_BYTES  = 700;

    logic clk = 1'b0;
    logic rst_n;

    dfr_in_if  blob_ch();
    dfr_out_if result_ch();

    delta_frame_rle_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .blob   (blob_ch),
        .result (result_ch)
    );

    // Decoder state mirrored by the predictor.
    parse_state_t phase;
    logic [2:0]   hdr_pos;
    logic [7:0]   low_hold;
    logic [15:0]  img_left;
    logic [15:0]  img_top;
    logic [15:0]  rec_ctrl;
    logic [15:0]  rec_xpos;
    int           img_w;
    int           img_h;
    int           row_at;
    int           col_at;
    int           pix_left;
    int           pkt_left;
    logic         rec_coded;

    result_t    due_results[$];
    logic [7:0] blob_bytes[$];
    stim_row_t  directed [DIRECTED_ROWS];
    int         failures;
    int         fed_bytes;
    bit         src_idle;
    bit         sink_idle;

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL delta_frame_rle_decoder");
        $finish;
    end

    function automatic int sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic void push_write(input int len, input logic [7:0] val);
        result_t r;
        r = '0;
        r.kind = KIND_WRITE;
        r.pixel_row = row_at[12:0];
        r.pixel_column = col_at[12:0];
        r.run_length = len[6:0];
        r.pixel_value = val;
        due_results.push_back(r);
    endfunction

    function automatic void push_finish(input logic [2:0] code, input logic last);
        result_t r;
        r = '0;
        r.kind = (code == ERR_NONE) ? KIND_DONE : KIND_ERROR;
        r.error_code = code;
        due_results.push_back(r);
        phase = last ? ST_HEADER : ST_DRAIN;
        hdr_pos = '0;
    endfunction

    // After a payload byte: at the record's end move on to the next record header, else flag a truncated last byte.
    function automatic void payload_end(input logic last);
        if (pix_left == 0)
        begin
            phase = ST_RECORD;
            hdr_pos = '0;
            if (last)
                push_finish(ERR_NONE, 1'b1);
        end
        else if (last)
            push_finish(ERR_TRUNCATED, 1'b1);
    endfunction

    function automatic void clear_decoder();
        phase = ST_HEADER;
        hdr_pos = '0;
        low_hold = '0;
        img_left = '0;
        img_top = '0;
        rec_ctrl = '0;
        rec_xpos = '0;
        img_w = 0;
        img_h = 0;
        row_at = 0;
        col_at = 0;
        pix_left = 0;
        pkt_left = 0;
        rec_coded = 1'b0;
    endfunction

    // Appends to due_results every result that one blob byte causes.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int start;
        int w;
        int h;
        int col;
        int row;
        int cnt;
        int len;
        bit done;
        logic [15:0] word;
        result_t r;
        start = due_results.size();
        word = {b, low_hold};
        done = 1'b0;
        case (phase)
            ST_HEADER:
            begin
                if (hdr_pos == HDR_LEFT_HI)
                    img_left = word;
                else if (hdr_pos == HDR_TOP_HI)
                    img_top = word;
                else if (hdr_pos == HDR_RIGHT_HI)
                    rec_ctrl = word;
                else if (hdr_pos == HDR_BOTTOM_HI)
                begin
                    w = sext16(rec_ctrl) + 1 - sext16(img_left);
                    h = sext16(word) + 1 - sext16(img_top);
                    if (w <= 0 || h <= 0 || w > 8192 || h > 8192)
                        push_finish(ERR_BAD_SIZE, last);
                    else
                    begin
                        img_w = w;
                        img_h = h;
                        r = '0;
                        r.kind = KIND_GEOM;
                        r.origin_x = img_left;
                        r.origin_y = img_top;
                        r.image_width = w[13:0];
                        r.image_height = h[13:0];
                        due_results.push_back(r);
                        phase = ST_RECORD;
                        hdr_pos = '0;
                        if (last)
                            push_finish(ERR_NONE, 1'b1);
                    end
                end
                if (phase == ST_HEADER && hdr_pos < HDR_BOTTOM_HI
                    && due_results.size() == start)
                begin
                    low_hold = b;
                    hdr_pos++;
                    if (last)
                        push_finish(ERR_SHORT_HEADER, 1'b1);
                end
            end
            ST_RECORD:
            begin
                if (hdr_pos == REC_CTRL_HI)
                begin
                    rec_ctrl = word;
                    if (word == 16'h0000)
                    begin
                        push_finish(ERR_NONE, last);
                        done = 1'b1;
                    end
                end
                else if (hdr_pos == REC_X_HI)
                    rec_xpos = word;
                else if (hdr_pos == REC_Y_HI)
                begin
                    done = 1'b1;
                    col = sext16(rec_xpos) - sext16(img_left);
                    row = sext16(word) - sext16(img_top);
                    cnt = int'(rec_ctrl[15:1]);
                    if (col < 0 || row < 0 || col + cnt > img_w || row >= img_h)
                        push_finish(ERR_BOUNDS, last);
                    else
                    begin
                        row_at = row;
                        col_at = col;
                        pix_left = cnt;
                        rec_coded = rec_ctrl[0];
                        hdr_pos = '0;
                        if (cnt == 0)
                        begin
                            // An empty coded record only moves on to the next header.
                            if (last)
                                push_finish(ERR_NONE, 1'b1);
                        end
                        else
                        begin
                            phase = rec_coded ? ST_PACKET : ST_RAW;
                            if (last)
                                push_finish(ERR_TRUNCATED, 1'b1);
                        end
                    end
                end
                if (!done)
                begin
                    low_hold = b;
                    hdr_pos++;
                    if (last)
                        push_finish(ERR_NONE, 1'b1);
                end
            end
            ST_RAW:
            begin
                push_write(1, b);
                col_at++;
                pix_left--;
                payload_end(last);
            end
            ST_PACKET:
            begin
                len = int'(b[7:1]);
                if (len == 0)
                    push_finish(ERR_ZERO_RUN, last);
                else if (len > pix_left)
                    push_finish(ERR_OVERFLOW, last);
                else
                begin
                    pkt_left = len;
                    phase = b[0] ? ST_FILL : ST_LITERAL;
                    if (last)
                        push_finish(ERR_TRUNCATED, 1'b1);
                end
            end
            ST_FILL:
            begin
                push_write(pkt_left, b);
                col_at += pkt_left;
                pix_left -= pkt_left;
                pkt_left = 0;
                phase = ST_PACKET;
                payload_end(last);
            end
            ST_LITERAL:
            begin
                push_write(1, b);
                col_at++;
                pix_left--;
                pkt_left--;
                if (pkt_left == 0)
                    phase = ST_PACKET;
                if (pkt_left == 0 || pix_left == 0)
                    payload_end(last);
                else if (last)
                    push_finish(ERR_TRUNCATED, 1'b1);
            end
            default:
            begin
                if (last)
                begin
                    phase = ST_HEADER;
                    hdr_pos = '0;
                end
            end
        endcase
        col_at &= 'h3FFF;
        pix_left &= 'h7FFF;
        if (due_results.size() > start)
            due_results[due_results.size() - 1].end_of_run = 1'b1;
    endfunction

    // Sends one byte, then records what it should cause.
    task automatic feed_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [1:0] kind, input logic [2:0] code);
        int gap;
        int start;
        result_t r;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            blob_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blob_ch.valid <= 1'b1;
        blob_ch.data_byte <= b;
        blob_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!blob_ch.ready);
        fed_bytes++;
        start = due_results.size();
        decode_byte(b, last);
        if (typed)
        begin
            if (due_results.size() == start)
            begin
                r = '0;
                r.end_of_run = 1'b1;
                due_results.push_back(r);
            end
            due_results[due_results.size() - 1].kind = kind;
            due_results[due_results.size() - 1].error_code = code;
        end
    endtask

    // Holds the input back until every outstanding result has been seen.
    task automatic drain_results();
        if (due_results.size() != 0)
        begin
            blob_ch.valid <= 1'b0;
            while (due_results.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic void put_word(input int v);
        blob_bytes.push_back(v[7:0]);
        blob_bytes.push_back(v[15:8]);
    endfunction

    // Mostly small images; now and then the largest size, any size up to it, or one just past it.
    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8192;
        if (r == 1)
            return $urandom_range(1, 8192);
        if (r == 2)
            return 8193;
        return $urandom_range(1, 40);
    endfunction

    // Builds a blob, then perhaps cuts it short, damages one byte or replaces it with random bytes.
    function automatic void build_blob();
        int w;
        int h;
        int left;
        int top;
        int col;
        int row;
        int cnt;
        int rem;
        int len;
        int keep;
        int pick;
        bit coded;
        blob_bytes.delete();
        w = pick_dim();
        h = pick_dim();
        left = $urandom_range(0, 65536 - w) - 32768;
        top = $urandom_range(0, 65536 - h) - 32768;
        put_word(left);
        put_word(top);
        put_word(left + w - 1);
        put_word(top + h - 1);
        repeat ($urandom_range(0, 4))
        begin
            col = $urandom_range(0, w - 1);
            row = $urandom_range(0, h - 1);
            coded = ($urandom_range(0, 1) != 0);
            if (coded)
                cnt = $urandom_range(0, (w - col) > 260 ? 260 : (w - col));
            else
                cnt = $urandom_range(1, (w - col) > 12 ? 12 : (w - col));
            put_word(cnt * 2 + int'(coded));
            put_word(left + col);
            put_word(top + row);
            if (!coded)
                repeat (cnt) blob_bytes.push_back(8'($urandom_range(0, 255)));
            rem = coded ? cnt : 0;
            while (rem > 0)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    if (rem >= 127 && $urandom_range(0, 1) == 1)
                        len = 127;
                    else
                        len = $urandom_range(1, rem > 127 ? 127 : rem);
                    blob_bytes.push_back({len[6:0], 1'b1});
                    blob_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    len = $urandom_range(1, rem > 4 ? 4 : rem);
                    blob_bytes.push_back({len[6:0], 1'b0});
                    repeat (len) blob_bytes.push_back(8'($urandom_range(0, 255)));
                end
                rem -= len;
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            put_word(0);
            repeat ($urandom_range(0, 3)) blob_bytes.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 9);
        if (pick == 5 || pick == 6)
        begin
            keep = $urandom_range(1, blob_bytes.size());
            while (blob_bytes.size() > keep)
                void'(blob_bytes.pop_back());
        end
        else if (pick == 7 || pick == 8)
            blob_bytes[$urandom_range(0, blob_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        else if (pick == 9)
        begin
            blob_bytes.delete();
            repeat ($urandom_range(1, 30)) blob_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic string show(input result_t r);
        return {$sformatf("kind=%0d x=%0d y=%0d w=%0d h=%0d ",
                    r.kind, r.origin_x, r.origin_y, r.image_width, r.image_height),
                $sformatf("row=%0d col=%0d len=%0d val=%0d err=%0d eor=%0d",
                    r.pixel_row, r.pixel_column, r.run_length, r.pixel_value,
                    r.error_code, r.end_of_run)};
    endfunction

    // Result side: random stalls, each accepted item checked against the oldest expectation.
    initial
    begin
        int stall;
        result_t got;
        result_t want;
        result_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got = {result_ch.kind, result_ch.origin_x, result_ch.origin_y,
                   result_ch.image_width, result_ch.image_height, result_ch.pixel_row,
                   result_ch.pixel_column, result_ch.run_length, result_ch.pixel_value,
                   result_ch.error_code, result_ch.end_of_run};
            if (due_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing expected: %s", $realtime, show(got));
            end
            else
            begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.origin_x !== want.origin_x
                    || got.origin_y !== want.origin_y
                    || got.image_width !== want.image_width
                    || got.image_height !== want.image_height
                    || got.pixel_row !== want.pixel_row
                    || got.pixel_column !== want.pixel_column
                    || got.run_length !== want.run_length
                    || got.pixel_value !== want.pixel_value
                    || got.error_code !== want.error_code
                    || got.end_of_run !== want.end_of_run)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, show(want), show(got));
                end
            end
            if ($urandom_range(0, 39) == 0)
                sink_idle = $urandom_range(0, 2) != 0;
        end
    end

    initial
    begin
        int blob_count;
        rst_n <= 1'b0;
        blob_ch.valid <= 1'b0;
        blob_ch.data_byte <= '0;
        blob_ch.last_byte <= 1'b0;
        failures = 0;
        fed_bytes = 0;
        blob_count = 0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        clear_decoder();
        // Short header right after reset; a header whose right edge wraps below the
        // left edge; the widest image at the extreme origins; a zero-length packet.
        directed = '{
            '{8'h5A, 1'b1, TYPED,   KIND_ERROR, ERR_SHORT_HEADER},
            '{8'hFF, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h7F, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h80, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b1, TYPED,   KIND_ERROR, ERR_BAD_SIZE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h80, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'hFF, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h7F, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'hFF, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h9F, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'hFF, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h7F, 1'b0, TYPED,   KIND_GEOM,  ERR_NONE},
            '{8'h03, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h80, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'hFF, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h7F, 1'b0, MODELED, KIND_GEOM,  ERR_NONE},
            '{8'h00, 1'b1, TYPED,   KIND_ERROR, ERR_ZERO_RUN}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            feed_byte(directed[i].data, directed[i].last, directed[i].typed,
                      directed[i].kind, directed[i].code);
        fed_bytes = 0;
        while (fed_bytes < RANDOM_BYTES)
        begin
            if (blob_count % 8 == 0)
                drain_results();
            build_blob();
            for (int i = 0; i < blob_bytes.size(); i++)
                feed_byte(blob_bytes[i], i == blob_bytes.size() - 1, MODELED,
                          KIND_GEOM, ERR_NONE);
            blob_count++;
            src_idle = $urandom_range(0, 3) != 0;
        end
        blob_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (failures == 0)
            $display("PASS delta_frame_rle_decoder");
        else
            $display("FAIL delta_frame_rle_decoder");
        $finish;
    end

endmodule

// File: files.f
sv/dfr_pkg.sv
sv/dfr_in_if.sv
sv/dfr_out_if.sv
sv/dfr_front.sv
sv/dfr_queue.sv
sv/dfr_back.sv
sv/delta_frame_rle_decoder.sv
test/delta_frame_rle_decoder_test.sv
